// ----- src/swrf_pkg.sv -----
// Package for the sliding-window rank filter: shared constants, register
// indexes and the command/status structs between controller and datapath.
// Depends on nothing.
package swrf_pkg;

   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int REG_BITS       = 7;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_RANK_SELECT   = CSR_INDEX_BITS'(1);

   localparam logic [REG_BITS-1:0] WINDOW_LENGTH_RESET = REG_BITS'(16);
   localparam logic [REG_BITS-1:0] RANK_SELECT_RESET   = REG_BITS'(8);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;        // latch the incoming sample and classify it
      logic load_result;   // move the result into the output register
      logic stream_start;  // clear merge counters and fetch sorted entry zero
      logic stream_step;   // one merge step of the sorted copy
      logic commit;        // swap sorted banks and update window pointers
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic differs;       // latched sample differs from the last appended one
      logic stream_done;   // every entry of the new sorted copy is written
      logic out_stall;     // output register holds a result not yet taken
   } dp_status_type;

endpackage

// ----- src/swrf_if.sv -----
// Channel interfaces of the rank filter: sample requests, results and
// register writes. Depends on swrf_pkg.
interface swrf_req_if import swrf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swrf_rsp_if import swrf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] smoothed;
   logic                          window_full;

   modport source (output valid, output smoothed, output window_full, input ready);
   modport sink   (input valid, input smoothed, input window_full, output ready);
endinterface

interface swrf_csr_if import swrf_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/swrf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module swrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/swrf_ctrl.sv -----
// Controller of the rank filter: sequences accept, result, and the merge
// pass that rebuilds the sorted copy. Depends on swrf_pkg.
module swrf_ctrl import swrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RESULT,
      S_PRIME,
      S_STREAM,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid & ready_ff;
            if (cmd.accept) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!status.out_stall) begin
               cmd.load_result = 1'b1;
               state_in        = status.differs ? S_PRIME : S_IDLE;
            end
         end
         S_PRIME: begin
            cmd.stream_start = 1'b1;
            state_in         = S_STREAM;
         end
         S_STREAM: begin
            if (status.stream_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.stream_step = 1'b1;
            end
         end
         S_FINISH: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// ----- src/swrf_datapath.sv -----
// Datapath of the rank filter: window FIFO, ping-pong sorted copy, merge
// logic, registers and output register. Depends on swrf_pkg and swrf_ram.
module swrf_datapath import swrf_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   output dp_status_type                 status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_smoothed,
   output logic                          rsp_window_full
);

   localparam int IW = $clog2(WINDOW_MAX);       // window slot index
   localparam int CW = $clog2(WINDOW_MAX + 1);   // count up to WINDOW_MAX
   localparam int SW = IW + 1;                   // sorted RAM address: bank and slot
   localparam logic [CW:0] MAX_W = (CW + 1)'(WINDOW_MAX);

   // Registers.
   logic [REG_BITS-1:0]          window_length_ff;
   logic [REG_BITS-1:0]          rank_select_ff;
   logic [CW-1:0]                fill_ff;
   logic [IW-1:0]                oldest_ff;
   logic [SAMPLE_BITS-1:0]       last_ff;
   logic                         bank_ff;
   logic                         rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                         full_ff;
   logic                         differs_ff;
   logic [CW-1:0]                cur_idx_ff, cur_idx_in;
   logic [CW-1:0]                wr_idx_ff;
   logic                         inserted_ff;
   logic                         deleted_ff;
   logic signed [SAMPLE_BITS-1:0] smoothed_ff;
   logic                         window_full_ff;

   logic [CW-1:0]          eff_len;
   logic [CW-1:0]          rank_eff;
   logic [IW-1:0]          rank_idx;
   logic [CW-1:0]          n_new;
   logic                   done;
   logic [CW:0]            tail_sum;
   logic [IW-1:0]          tail_idx;
   logic [IW-1:0]          oldest_in;

   logic [SAMPLE_BITS-1:0] sort_rd_data;
   logic [SAMPLE_BITS-1:0] fifo_rd_data;
   logic [IW-1:0]          rd_idx;
   logic                   cur_valid, skip, take_ins, take_cur, consume, emit;
   logic [SAMPLE_BITS-1:0] merge_data;

   // Effective window length and rank, clamped.
   always_comb begin
      if (window_length_ff == '0) begin
         eff_len = CW'(1);
      end else if (int'(window_length_ff) > WINDOW_MAX) begin
         eff_len = CW'(WINDOW_MAX);
      end else begin
         eff_len = CW'(window_length_ff);
      end
      if (rank_select_ff == '0) begin
         rank_eff = CW'(1);
      end else if (int'(rank_select_ff) > int'(eff_len)) begin
         rank_eff = eff_len;
      end else begin
         rank_eff = CW'(rank_select_ff);
      end
   end

   assign rank_idx = IW'(rank_eff - CW'(1));
   assign n_new    = full_ff ? fill_ff : fill_ff + CW'(1);
   assign done     = (wr_idx_ff == n_new);

   // Merge step: drop one copy of the oldest entry when the window is full, insert the new sample.
   assign cur_valid = (cur_idx_ff < fill_ff);
   assign skip      = cur_valid & full_ff & ~deleted_ff & (sort_rd_data == fifo_rd_data);
   assign take_ins  = ~skip & ~inserted_ff
                      & (~cur_valid | (sample_ff < $signed(sort_rd_data)));
   assign take_cur  = ~skip & ~take_ins & cur_valid;
   assign consume   = skip | take_cur;
   assign emit      = take_ins | take_cur;
   assign merge_data = take_ins ? sample_ff : sort_rd_data;
   assign cur_idx_in = consume ? cur_idx_ff + CW'(1) : cur_idx_ff;

   always_comb begin
      if (cmd.stream_start) begin
         rd_idx = '0;
      end else if (cmd.stream_step) begin
         rd_idx = IW'(cur_idx_in);
      end else begin
         rd_idx = rank_idx;
      end
   end

   // Tail slot of the circular window and the advanced oldest pointer.
   assign tail_sum  = (CW + 1)'(oldest_ff) + (CW + 1)'(fill_ff);
   assign tail_idx  = (tail_sum >= MAX_W) ? IW'(tail_sum - MAX_W) : IW'(tail_sum);
   assign oldest_in = (oldest_ff == IW'(WINDOW_MAX - 1)) ? '0 : oldest_ff + IW'(1);

   swrf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (2 ** SW)
   ) u_sorted_ram (
      .clock   (clock),
      .wr_en   (cmd.stream_step & emit),
      .wr_addr ({~bank_ff, IW'(wr_idx_ff)}),
      .wr_data (merge_data),
      .rd_addr ({bank_ff, rd_idx}),
      .rd_data (sort_rd_data)
   );

   swrf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (tail_idx),
      .wr_data (sample_ff),
      .rd_addr (oldest_ff),
      .rd_data (fifo_rd_data)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         rank_select_ff   <= RANK_SELECT_RESET;
         fill_ff          <= '0;
         oldest_ff        <= '0;
         last_ff          <= '0;
         bank_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_WINDOW_LENGTH: begin
                  window_length_ff <= csr_data[REG_BITS-1:0];
                  fill_ff          <= '0;
                  oldest_ff        <= '0;
               end
               REG_RANK_SELECT: begin
                  rank_select_ff <= csr_data[REG_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            bank_ff <= ~bank_ff;
            fill_ff <= n_new;
            last_ff <= sample_ff;
            if (full_ff) begin
               oldest_ff <= oldest_in;
            end
         end
         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-item payload and merge counters.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff  <= req_sample;
         full_ff    <= (fill_ff == eff_len);
         differs_ff <= (req_sample != $signed(last_ff));
      end
      if (cmd.stream_start) begin
         cur_idx_ff  <= '0;
         wr_idx_ff   <= '0;
         inserted_ff <= 1'b0;
         deleted_ff  <= 1'b0;
      end else if (cmd.stream_step) begin
         cur_idx_ff <= cur_idx_in;
         if (emit) begin
            wr_idx_ff <= wr_idx_ff + CW'(1);
         end
         if (take_ins) begin
            inserted_ff <= 1'b1;
         end
         if (skip) begin
            deleted_ff <= 1'b1;
         end
      end
      if (cmd.load_result) begin
         smoothed_ff    <= full_ff ? $signed(sort_rd_data) : sample_ff;
         window_full_ff <= full_ff;
      end
   end

   assign status.differs     = differs_ff;
   assign status.stream_done = done;
   assign status.out_stall   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_smoothed    = smoothed_ff;
   assign rsp_window_full = window_full_ff;

endmodule

// ----- src/sliding_window_rank_filter_core.sv -----
// Top level of the sliding-window rank filter: controller and datapath.
// Depends on swrf_pkg, swrf_if, swrf_ctrl, swrf_datapath and swrf_ram.
//
// This block takes one signed sample per item and returns one result item per
// sample. It keeps a FIFO window of past samples, appending a sample only when
// it differs from the last appended one. While the window is still filling the
// sample comes back unchanged with window_full low; once the window holds
// window_length entries, the result is the rank_select-th smallest entry of
// the window as it stood before this sample, with window_full high, and a
// differing sample then replaces the oldest entry. Both registers are clamped
// (length to 1..WINDOW_MAX, rank to 1..length), and writing window_length
// empties the window. Besides the circular window memory the block keeps a
// sorted copy of the window in a two-bank memory, so the rank pick is a single
// read. An item that appends nothing has its result loaded in the result state
// that follows acceptance, and the block then returns to idle; it takes no new
// item before that. An item that appends also loads its result there, then
// rebuilds the sorted copy in one merge pass over the other bank: a prime
// state fetches sorted entry zero, the stream state merges one entry per
// cycle through the single read port, and a finish state swaps the banks and
// appends the sample to the window memory before the block returns to idle.
// A result that cannot enter the output register because the previous one
// has not been taken holds the block in the result state. The result sits in
// an output register, so the next item is accepted while it waits to be taken.
// No clearing pass is needed after reset; the block is ready at once.
// Register writes are accepted only while the block is idle.
module sliding_window_rank_filter_core import swrf_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   swrf_req_if.sink          req_ch,
   swrf_rsp_if.source        rsp_ch,
   swrf_csr_if.sink          csr_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          ready;

   // The controller sequences each item; the datapath holds all storage.
   swrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   swrf_datapath #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_ch.sample),
      .csr_write       (csr_ch.valid & ready),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_smoothed    (rsp_ch.smoothed),
      .rsp_window_full (rsp_ch.window_full)
   );

   // Sample items and register writes are both taken only while idle.
   assign req_ch.ready = ready;
   assign csr_ch.ready = ready;

endmodule

// ----- src/swrf_checker.sv -----
// Port-level checks of the rank filter and the bind that attaches them to
// the top level. Depends on swrf_pkg and sliding_window_rank_filter_core.
module swrf_checker import swrf_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_smoothed,
   input logic                   rsp_window_full,
   input logic                   csr_ready
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smoothed)
                                  && $stable(rsp_window_full))
      else $error("result changed while stalled");

   // An accepted item makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted item");

   // Register writes and sample items share the idle window.
   assert property (@(posedge clock) disable iff (reset)
      csr_ready == req_ready)
      else $error("register port ready differs from request ready");

   // A new result is only loaded while the block is busy with an item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without an item in progress");

endmodule

bind sliding_window_rank_filter_core swrf_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_swrf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_smoothed    (rsp_ch.smoothed),
   .rsp_window_full (rsp_ch.window_full),
   .csr_ready       (csr_ch.ready)
);
